/* sv/trt_pkg.sv */
// ----------------------------------------------------------------------------
// Trailing reference tracker package
// Widths, register indexes and defaults shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int CHANNELS_DEFAULT = 256;
  localparam int CH_W             = 8;
  localparam int PRICE_W          = 32;
  localparam int FRAC_W           = 16;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'd1;

endpackage

/* sv/trt_if.sv */
// ----------------------------------------------------------------------------
// Trailing reference tracker stream interfaces
// Valid/ready channels for incoming price words and outgoing reference words.
// ----------------------------------------------------------------------------
interface trt_feed_if;
  logic                        valid;
  logic                        ready;
  logic [trt_pkg::CH_W-1:0]    channel;
  logic [trt_pkg::PRICE_W-1:0] close_price;
  logic                        first_row;

  modport source (output valid, channel, close_price, first_row, input ready);
  modport sink   (input valid, channel, close_price, first_row, output ready);
endinterface

interface trt_result_if;
  logic                        valid;
  logic                        ready;
  logic [trt_pkg::CH_W-1:0]    out_channel;
  logic [trt_pkg::PRICE_W-1:0] reference;
  logic                        sold;

  modport source (output valid, out_channel, reference, sold, input ready);
  modport sink   (input valid, out_channel, reference, sold, output ready);
endinterface

/* sv/trailing_reference_tracker.sv */
// ----------------------------------------------------------------------------
// Trailing reference tracker
// Per-channel trailing reference line kept in one synchronous memory.
// An accepted price word moves through stages 1 to 3 and the output register.
// Words on different channels are taken one per cycle unless the output stalls;
// a word on the channel of one in stage 1 or 2, or held in stage 3, waits.
// Reset clears the pipeline and the fraction registers; the memory is not
// cleared, so a channel must be started by a first-row word.
// ----------------------------------------------------------------------------
module trailing_reference_tracker #(
  parameter int CHANNELS = trt_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [trt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trt_pkg::FRAC_W-1:0]    cfg_data,
  trt_feed_if.sink                      feed,
  trt_result_if.source                  result
);
  import trt_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {MODE_BELOW, MODE_ABOVE, MODE_UP, MODE_DOWN} mode_t;

  typedef struct packed {
    logic [PRICE_W-1:0] level;
    logic               sold;
  } entry_t;

  function automatic logic [IDX_W-1:0] chan_index(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] rem;
    rem = ch;
    for (int k = CH_W - 1; k >= 0; k--) begin
      if (int'(rem) >= (CHANNELS << k)) begin
        rem = rem - CH_W'(CHANNELS << k);
      end
    end
    return IDX_W'(rem);
  endfunction

  logic [FRAC_W-1:0] start_fraction;
  logic [FRAC_W-1:0] step_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_fraction <= '0;
      step_fraction  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START: start_fraction <= cfg_data;
        REG_STEP:  step_fraction  <= cfg_data;
        default: ;
      endcase
    end
  end

  entry_t mem [CHANNELS];
  entry_t rd_entry;

  // Stage 1: memory read data available.
  logic               s1_valid;
  logic [CH_W-1:0]    s1_ch;
  logic [IDX_W-1:0]   s1_idx;
  logic [PRICE_W-1:0] s1_price;
  logic               s1_first;
  logic               s1_fwd;
  entry_t             s1_fwd_entry;

  // Stage 2: mode chosen, gap formed.
  logic               s2_valid;
  logic [CH_W-1:0]    s2_ch;
  logic [IDX_W-1:0]   s2_idx;
  logic [PRICE_W-1:0] s2_price;
  logic [PRICE_W-1:0] s2_level;
  logic [PRICE_W-1:0] s2_gap;
  mode_t              s2_mode;
  logic               s2_sold;

  // Stage 3: products ready.
  logic               s3_valid;
  logic [CH_W-1:0]    s3_ch;
  logic [IDX_W-1:0]   s3_idx;
  logic [PRICE_W-1:0] s3_price;
  logic [PRICE_W-1:0] s3_level;
  logic [PRICE_W-1:0] s3_gap_part;
  logic [PRICE_W-1:0] s3_band_part;
  mode_t              s3_mode;
  logic               s3_sold;

  // Output register.
  logic               o_valid;
  logic [CH_W-1:0]    o_ch;
  entry_t             o_entry;

  logic               o_free, s3_free, s2_free, s1_free;
  logic               adv1, adv2, adv3;
  logic [IDX_W-1:0]   in_idx;
  logic               hazard, fwd_hit, accept;
  entry_t             wr_entry;

  assign o_free  = !o_valid || result.ready;
  assign adv3    = s3_valid && o_free;
  assign s3_free = !s3_valid || o_free;
  assign adv2    = s2_valid && s3_free;
  assign s2_free = !s2_valid || s3_free;
  assign adv1    = s1_valid && s2_free;
  assign s1_free = !s1_valid || s2_free;

  assign in_idx  = chan_index(feed.channel);
  assign fwd_hit = adv3 && (s3_idx == in_idx);
  assign hazard  = (s1_valid && (s1_idx == in_idx))
                || (s2_valid && (s2_idx == in_idx))
                || (s3_valid && (s3_idx == in_idx) && !adv3);
  assign feed.ready = s1_free && !hazard;
  assign accept     = feed.valid && feed.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_entry <= mem[in_idx];
    end
    if (adv3) begin
      mem[s3_idx] <= wr_entry;
    end
  end

  // Stage 1 decision logic.
  logic [PRICE_W-1:0] cur_level;
  logic               cur_sold;
  logic [PRICE_W:0]   diff_up;
  logic [PRICE_W-1:0] diff_down;
  logic               price_below;
  logic               price_above;
  mode_t              mode_next;
  logic               sold_next;
  logic [PRICE_W-1:0] gap_next;

  always_comb begin
    cur_level   = s1_fwd ? s1_fwd_entry.level : rd_entry.level;
    cur_sold    = s1_fwd ? s1_fwd_entry.sold  : rd_entry.sold;
    diff_up     = {1'b0, s1_price} - {1'b0, cur_level};
    diff_down   = cur_level - s1_price;
    price_below = diff_up[PRICE_W];
    price_above = !diff_up[PRICE_W] && (diff_up[PRICE_W-1:0] != '0);
    gap_next    = price_below ? diff_down : diff_up[PRICE_W-1:0];
    if (s1_first) begin
      mode_next = MODE_BELOW;
      sold_next = 1'b0;
    end else if (cur_sold) begin
      if (price_above) begin
        mode_next = MODE_BELOW;
        sold_next = 1'b0;
      end else begin
        mode_next = MODE_DOWN;
        sold_next = 1'b1;
      end
    end else begin
      if (price_below) begin
        mode_next = MODE_ABOVE;
        sold_next = 1'b1;
      end else begin
        mode_next = MODE_UP;
        sold_next = 1'b0;
      end
    end
  end

  // Stage 2 products.
  logic [PRICE_W+FRAC_W-1:0] gap_prod;
  logic [PRICE_W+FRAC_W-1:0] band_prod;

  assign gap_prod  = s2_gap * step_fraction;
  assign band_prod = s2_price * start_fraction;

  // Stage 3 final update.
  logic [PRICE_W:0] band_sum;

  always_comb begin
    band_sum       = {1'b0, s3_price} + {1'b0, s3_band_part};
    wr_entry.sold  = s3_sold;
    case (s3_mode)
      MODE_BELOW: wr_entry.level = s3_price - s3_band_part;
      MODE_ABOVE: wr_entry.level = band_sum[PRICE_W] ? '1 : band_sum[PRICE_W-1:0];
      MODE_UP:    wr_entry.level = s3_level + s3_gap_part;
      MODE_DOWN:  wr_entry.level = s3_level - s3_gap_part;
      default:    wr_entry.level = s3_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv1) begin
        s1_valid <= 1'b0;
      end
      if (adv1) begin
        s2_valid <= 1'b1;
      end else if (adv2) begin
        s2_valid <= 1'b0;
      end
      if (adv2) begin
        s3_valid <= 1'b1;
      end else if (adv3) begin
        s3_valid <= 1'b0;
      end
      if (adv3) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch        <= feed.channel;
      s1_idx       <= in_idx;
      s1_price     <= feed.close_price;
      s1_first     <= feed.first_row;
      s1_fwd       <= fwd_hit;
      s1_fwd_entry <= wr_entry;
    end
    if (adv1) begin
      s2_ch    <= s1_ch;
      s2_idx   <= s1_idx;
      s2_price <= s1_price;
      s2_level <= cur_level;
      s2_gap   <= gap_next;
      s2_mode  <= mode_next;
      s2_sold  <= sold_next;
    end
    if (adv2) begin
      s3_ch        <= s2_ch;
      s3_idx       <= s2_idx;
      s3_price     <= s2_price;
      s3_level     <= s2_level;
      s3_gap_part  <= gap_prod[PRICE_W+FRAC_W-1:FRAC_W];
      s3_band_part <= band_prod[PRICE_W+FRAC_W-1:FRAC_W];
      s3_mode      <= s2_mode;
      s3_sold      <= s2_sold;
    end
    if (adv3) begin
      o_ch    <= s3_ch;
      o_entry <= wr_entry;
    end
  end

  assign result.valid       = o_valid;
  assign result.out_channel = o_ch;
  assign result.reference   = o_entry.level;
  assign result.sold        = o_entry.sold;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Trailing reference tracker testbench
// Drives price words through the feed channel and checks every reference word
// against an in-bench model of the per-channel trailing line or a table value.
// A short table of directed words is run first, then randomised phases under
// several fraction settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import trt_pkg::*;

  localparam int CHANNELS = CHANNELS_DEFAULT;
  localparam int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LIMIT    = 200000;
  localparam int PHASES   = 8;
  localparam int PER_PHASE = 144;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [PRICE_W-1:0] level;
    logic               sold;
  } level_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [FRAC_W-1:0]    reg_data;
    logic [CH_W-1:0]      ch;
    logic [PRICE_W-1:0]   price;
    logic                 first;
    logic                 known;
    logic [PRICE_W-1:0]   level;
    logic                 sold;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAC_W-1:0]    cfg_data;

  trt_feed_if   feed ();
  trt_result_if result ();

  trailing_reference_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed),
    .result    (result)
  );

  logic [PRICE_W-1:0] level_mem [CHANNELS];
  logic               sold_mem  [CHANNELS];
  logic [FRAC_W-1:0]  start_frac;
  logic [FRAC_W-1:0]  step_frac;
  bit                 live [256];
  logic [PRICE_W-1:0] last_price [256];
  level_word_t        pending_levels [$];
  int                 fails;
  int                 cycles;
  bit                 calm;
  row_t               plan [25];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [PRICE_W-1:0] part_of(logic [PRICE_W-1:0] x,
                                                 logic [FRAC_W-1:0] f);
    logic [47:0] prod;
    prod = {16'd0, x} * {32'd0, f};
    return prod[47:16];
  endfunction

  function automatic level_word_t advance_level(logic [CH_W-1:0] ch,
                                                logic [PRICE_W-1:0] price,
                                                logic first);
    level_word_t        w;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] lvl;
    logic               sold;
    logic [PRICE_W:0]   sum;
    slot = SLOT_W'(ch % CHANNELS);
    lvl  = level_mem[slot];
    sold = sold_mem[slot];
    if (first) begin
      sold = 1'b0;
      lvl  = price - part_of(price, start_frac);
    end else if (sold) begin
      if (price > lvl) begin
        sold = 1'b0;
        lvl  = price - part_of(price, start_frac);
      end else begin
        lvl = lvl - part_of(lvl - price, step_frac);
      end
    end else begin
      if (price < lvl) begin
        sold = 1'b1;
        sum  = {1'b0, price} + {1'b0, part_of(price, start_frac)};
        lvl  = sum[PRICE_W] ? '1 : sum[PRICE_W-1:0];
      end else begin
        lvl = lvl + part_of(price - lvl, step_frac);
      end
    end
    level_mem[slot] = lvl;
    sold_mem[slot]  = sold;
    w.ch    = ch;
    w.level = lvl;
    w.sold  = sold;
    return w;
  endfunction

  // Prices mostly wander around the channel's last price or its reference,
  // so that the line is crossed often in both directions.
  function automatic logic [PRICE_W-1:0] pick_price(logic [CH_W-1:0] ch);
    int                 sel;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] d;
    logic [PRICE_W:0]   t;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 32'd1;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    if (sel < 25 || !live[ch]) return $urandom;
    if (sel < 45) begin
      base = level_mem[SLOT_W'(ch % CHANNELS)];
      d    = $urandom_range(0, 16);
    end else begin
      base = last_price[ch];
      d    = $urandom_range(0, (base >> $urandom_range(3, 10)) + 1);
    end
    if ($urandom_range(0, 1)) begin
      t = {1'b0, base} + {1'b0, d};
      return t[PRICE_W] ? '1 : t[PRICE_W-1:0];
    end
    return (base >= d) ? base - d : '0;
  endfunction

  task automatic push_word(logic [CH_W-1:0] ch, logic [PRICE_W-1:0] price,
                           logic first, logic known, logic [PRICE_W-1:0] k_level,
                           logic k_sold);
    int          gap;
    level_word_t w;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid       <= 1'b1;
    feed.channel     <= ch;
    feed.close_price <= price;
    feed.first_row   <= first;
    @(negedge clk);
    while (!feed.ready) @(negedge clk);
    @(posedge clk);
    w = advance_level(ch, price, first);
    if (known) begin
      w.level = k_level;
      w.sold  = k_sold;
    end
    pending_levels.push_back(w);
    if (first) live[ch] = 1'b1;
    last_price[ch] = price;
  endtask

  task automatic drain();
    feed.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START) start_frac = data;
    else if (idx == REG_STEP) step_frac = data;
    @(posedge clk);
  endtask

  initial begin
    level_word_t got;
    level_word_t want;
    int          stall;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(negedge clk);
      while (!result.valid) @(negedge clk);
      got.ch    = result.out_channel;
      got.level = result.reference;
      got.sold  = result.sold;
      @(posedge clk);
      if (pending_levels.size() == 0) begin
        $error("reference word with nothing expected: channel %0h", got.ch);
        fails++;
      end else begin
        want = pending_levels.pop_front();
        if (got.ch !== want.ch) begin
          $error("out_channel expected %0h got %0h", want.ch, got.ch);
          fails++;
        end
        if (got.level !== want.level) begin
          $error("reference expected %0h got %0h", want.level, got.level);
          fails++;
        end
        if (got.sold !== want.sold) begin
          $error("sold expected %0h got %0h", want.sold, got.sold);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [CH_W-1:0]    ch;
    logic [PRICE_W-1:0] price;
    logic               first;
    logic [FRAC_W-1:0]  s_frac;
    logic [FRAC_W-1:0]  t_frac;
    fails      = 0;
    cycles     = 0;
    calm       = 1'b0;
    start_frac = '0;
    step_frac  = '0;
    foreach (level_mem[i]) begin
      level_mem[i] = '0;
      sold_mem[i]  = 1'b0;
    end
    foreach (live[i]) begin
      live[i]       = 1'b0;
      last_price[i] = '0;
    end
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    feed.valid       <= 1'b0;
    feed.channel     <= '0;
    feed.close_price <= '0;
    feed.first_row   <= 1'b0;

    plan = '{
      '{ROW_WORD, REG_START, 16'h0000, 8'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd0,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_WORD, REG_START, 16'h0000, 8'd0,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_WORD, REG_START, 16'h0000, 8'd0,   32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd255, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd255, 32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_REG,  REG_STEP,  16'hFFFF, 8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd2,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd3,   32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd3,   32'h0003_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd3,   32'h0003_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REG,  REG_START, 16'hFFFF, 8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd2,   32'hFFFF_FFFE, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_WORD, REG_START, 16'h0000, 8'd2,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd2,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd4,   32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd4,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd4,   32'h0000_1000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REG,  REG_START, 16'h1000, 8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_REG,  REG_STEP,  16'h4000, 8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd5,   32'h0080_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd5,   32'h0090_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd5,   32'h0070_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd5,   32'h0070_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{ROW_WORD, REG_START, 16'h0000, 8'd5,   32'h0080_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        push_word(plan[i].ch, plan[i].price, plan[i].first, plan[i].known,
                  plan[i].level, plan[i].sold);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin s_frac = 16'hFFFF; t_frac = 16'hFFFF; end
        1: begin s_frac = 16'h0000; t_frac = 16'hFFFF; end
        2: begin s_frac = 16'hFFFF; t_frac = 16'h0000; end
        3: begin s_frac = 16'h0000; t_frac = 16'h0000; end
        4, 6: begin
          s_frac = FRAC_W'($urandom_range(0, 16'h1FFF));
          t_frac = FRAC_W'($urandom_range(0, 16'h7FFF));
        end
        default: begin
          s_frac = FRAC_W'($urandom_range(0, 16'hFFFF));
          t_frac = FRAC_W'($urandom_range(0, 16'hFFFF));
        end
      endcase
      write_reg(REG_START, s_frac);
      write_reg(REG_STEP, t_frac);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        ch    = ($urandom_range(0, 1) != 0) ? CH_W'($urandom_range(0, 3))
                                            : CH_W'($urandom_range(0, 255));
        first = !live[ch] || ($urandom_range(0, 15) == 0);
        price = pick_price(ch);
        push_word(ch, price, first, 1'b0, '0, 1'b0);
      end
    end

    calm = 1'b0;
    drain();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
